### src/dfws_pkg.sv
// shared types and constants of the dds frequency word serial writer
`timescale 1ns / 1ps
`default_nettype none

package dfws_pkg;

    // field and register widths
    localparam int FREQ_BITS  = 27;
    localparam int MCLK_BITS  = 27;
    localparam int CTRL_BITS  = 16;
    localparam int TW_BITS    = 28;
    localparam int HALF_BITS  = 14;
    localparam int FRAME_BITS = 16;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS);
    localparam int DIV_CNT_W  = $clog2(TW_BITS);
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MCLK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CTRL = 1'd1;

    // reset values of the configuration registers
    localparam logic [MCLK_BITS-1:0] MCLK_RESET = 27'd75000000;
    localparam logic [CTRL_BITS-1:0] CTRL_RESET = 16'h2100;

    // data frame tags
    localparam logic [FRAME_BITS-1:0] TAG_REG0 = 16'h4000;
    localparam logic [FRAME_BITS-1:0] TAG_REG1 = 16'h8000;

    // word for exactly half the master clock
    localparam logic [TW_BITS-1:0] TW_HALF_CLK = 28'h8000000;

    // frame order within one update
    typedef enum logic [1:0] {
        FRAME_CTRL = 2'd0,
        FRAME_LO   = 2'd1,
        FRAME_HI   = 2'd2
    } t_frame;

    // tuning word with its register select, passed from front to back
    typedef struct packed {
        logic               sel;
        logic [TW_BITS-1:0] word;
    } t_tw_entry;

endpackage

`default_nettype wire

### src/dfws_in_if.sv
// request channel: frequency and register select
`timescale 1ns / 1ps
`default_nettype none

interface dfws_in_if
    import dfws_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FREQ_BITS-1:0] frequency_hz;
    logic                 select_reg;

    modport source (output valid, output frequency_hz, output select_reg, input ready);
    modport sink (input valid, input frequency_hz, input select_reg, output ready);
endinterface

`default_nettype wire

### src/dfws_out_if.sv
// serial bit channel: one item per shifted bit
`timescale 1ns / 1ps
`default_nettype none

interface dfws_out_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic [1:0] frame_index;
    logic       frame_end;
    logic       last;

    modport source (output valid, output serial_bit, output frame_index, output frame_end,
                    output last, input ready);
    modport sink (input valid, input serial_bit, input frame_index, input frame_end,
                  input last, output ready);
endinterface

`default_nettype wire

### src/dfws_front.sv
// front end: accepts requests and computes the tuning word by restoring division
`timescale 1ns / 1ps
`default_nettype none

module dfws_front
    import dfws_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dfws_in_if.sink                   s_item,
    input  wire logic [MCLK_BITS-1:0] i_mclk_hz,
    output      logic                 o_push,
    output      t_tw_entry            o_entry,
    input  wire logic                 i_full
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [TW_BITS-1:0]   r_rem, n_rem;
    logic [TW_BITS-1:0]   r_quo, n_quo;
    logic [TW_BITS-1:0]   r_den, n_den;
    logic [TW_BITS-1:0]   r_bits, n_bits;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_sel, n_sel;

    logic                 accept;
    logic [MCLK_BITS-1:0] clk_eff;
    logic [TW_BITS-1:0]   freq_x2;
    logic [TW_BITS:0]     trial;
    logic                 take;

    // a zero master clock counts as one
    assign clk_eff = (i_mclk_hz == '0) ? MCLK_BITS'(1) : i_mclk_hz;
    assign freq_x2 = {s_item.frequency_hz, 1'b0};

    // handshake: a finished word must leave before the next request loads
    assign o_push         = r_done && !i_full;
    assign s_item.ready   = !r_busy && (!r_done || !i_full);
    assign accept         = s_item.valid && s_item.ready;
    assign o_entry.sel    = r_sel;
    assign o_entry.word   = r_quo;

    // one quotient bit per cycle
    assign trial = {r_rem, r_bits[TW_BITS-1]};
    assign take  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_sel  = r_sel;
        if (accept) begin
            n_sel = s_item.select_reg;
            n_den = {clk_eff, 1'b0};
            n_rem = freq_x2;
            n_bits = {1'b0, clk_eff};
            n_cnt = DIV_CNT_W'(TW_BITS - 1);
            if (freq_x2 > {1'b0, clk_eff}) begin
                // above half the clock: clamp
                n_quo  = TW_HALF_CLK;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_quo  = '0;
                n_done = 1'b0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem  = take ? TW_BITS'(trial - {1'b0, r_den}) : trial[TW_BITS-1:0];
            n_quo  = {r_quo[TW_BITS-2:0], take};
            n_bits = {r_bits[TW_BITS-2:0], 1'b0};
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (o_push) begin
            n_done = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_sel  <= n_sel;
    end

endmodule

`default_nettype wire

### src/dfws_fifo.sv
// short queue of tuning words between front and back
`timescale 1ns / 1ps
`default_nettype none

module dfws_fifo
    import dfws_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_tw_entry i_entry,
    output      logic      o_full,
    input  wire logic      i_pop,
    output      logic      o_empty,
    output      t_tw_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tw_entry        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full   = r_count == CNT_W'(DEPTH);
    assign o_empty  = r_count == '0;
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_entry  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

### src/dfws_back.sv
// back end: builds the three frames and shifts them out one bit per item
`timescale 1ns / 1ps
`default_nettype none

module dfws_back
    import dfws_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  wire t_tw_entry            i_entry,
    output      logic                 o_pop,
    input  wire logic [CTRL_BITS-1:0] i_control_word,
    dfws_out_if.source                m_res
);

    logic                  r_active;
    logic [FRAME_BITS-1:0] r_shift;
    logic [BIT_CNT_W-1:0]  r_bit;
    t_frame                r_frm;
    t_tw_entry             r_cur;

    logic                  out_acc;
    logic                  frame_end;
    logic                  last_bit;
    logic [FRAME_BITS-1:0] tag;
    logic [FRAME_BITS-1:0] next_frame;
    t_frame                next_frm;

    assign frame_end = r_bit == BIT_CNT_W'(FRAME_BITS - 1);
    assign last_bit  = frame_end && (r_frm == FRAME_HI);
    assign out_acc   = m_res.valid && m_res.ready;
    assign o_pop     = !i_empty && (!r_active || (out_acc && last_bit));

    // result fields are registers or decoded straight from them
    assign m_res.valid       = r_active;
    assign m_res.serial_bit  = r_shift[FRAME_BITS-1];
    assign m_res.frame_index = r_frm;
    assign m_res.frame_end   = frame_end;
    assign m_res.last        = last_bit;

    // next data frame
    assign tag = r_cur.sel ? TAG_REG1 : TAG_REG0;
    always_comb begin
        unique case (r_frm)
            FRAME_CTRL: begin
                next_frm   = FRAME_LO;
                next_frame = tag | {2'b00, r_cur.word[HALF_BITS-1:0]};
            end
            FRAME_LO: begin
                next_frm   = FRAME_HI;
                next_frame = tag | {2'b00, r_cur.word[TW_BITS-1:HALF_BITS]};
            end
            default: begin
                next_frm   = FRAME_CTRL;
                next_frame = i_control_word;
            end
        endcase
    end

    // activity flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop) begin
            r_active <= 1'b1;
        end else if (out_acc && last_bit) begin
            r_active <= 1'b0;
        end
    end

    // shifter, counters and current word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
            r_frm <= FRAME_CTRL;
        end else if (o_pop) begin
            r_cur   <= i_entry;
            r_shift <= i_control_word;
            r_bit   <= '0;
            r_frm   <= FRAME_CTRL;
        end else if (out_acc) begin
            if (frame_end) begin
                r_shift <= next_frame;
                r_bit   <= '0;
                r_frm   <= next_frm;
            end else begin
                r_shift <= {r_shift[FRAME_BITS-2:0], 1'b0};
                r_bit   <= r_bit + BIT_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/dds_frequency_word_serial_writer.sv
// top level of the dds frequency word serial writer
//
// usage: i_item carries a frequency in hertz and a register select; o_res
// carries one item per shifted bit: the control frame, then tag plus the
// low 14 tuning bits, then tag plus the high 14 tuning bits, msb first,
// 48 items per request, with frame_end on each sixteenth bit and last on
// the final one. configuration is a plain write port: index 0 master
// clock, index 1 control word, and must be written only while the block
// is idle; the block itself does not enforce this. sequence: the front
// divider computes the word and pushes it into the queue; the back end
// then pops it and loads the shifter, which presents the first bit. a
// clamped frequency skips the division. throughput: the shifter sends
// one bit per cycle while o_res is ready; the divider serves the next request.
// reset: configuration returns to 75 MHz and 0x2100, queue and shifter
// empty. a stalled receiver holds the current bit; the queue then fills
// and i_item.ready drops until the shifter frees a slot.
`timescale 1ns / 1ps
`default_nettype none

module dds_frequency_word_serial_writer
    import dfws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dfws_in_if.sink                   i_item,
    dfws_out_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MCLK_BITS-1:0] i_cfg_data
);

    logic [MCLK_BITS-1:0] r_mclk_hz;
    logic [CTRL_BITS-1:0] r_control_word;

    logic      push, pop, full, empty;
    t_tw_entry front_entry, queue_entry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mclk_hz      <= MCLK_RESET;
            r_control_word <= CTRL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MCLK: r_mclk_hz      <= i_cfg_data;
                CFG_IDX_CTRL: r_control_word <= i_cfg_data[CTRL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // tuning word computation
    dfws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_item    (i_item),
        .i_mclk_hz (r_mclk_hz),
        .o_push    (push),
        .o_entry   (front_entry),
        .i_full    (full)
    );

    // decoupling queue
    dfws_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (queue_entry)
    );

    // frame serializer
    dfws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_entry        (queue_entry),
        .o_pop          (pop),
        .i_control_word (r_control_word),
        .m_res          (o_res)
    );

`ifndef NO_ASSERTIONS
    // an update never stops in the middle
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
        else $error("serial output went idle inside an update");

    // frames follow in order
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.frame_end && !o_res.last)
        |=> (o_res.frame_index == 2'($past(o_res.frame_index) + 2'd1)))
        else $error("frame index did not advance after a frame end");

    // last only on the end of the high half
    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.frame_end && o_res.frame_index == FRAME_HI))
        else $error("last flagged outside the end of the final frame");

    // a queued word never waits while the shifter is free
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_res.valid && !empty) |-> pop)
        else $error("idle shifter left a queued word waiting");
`endif

endmodule

`default_nettype wire
